/* hw/rtl/ray_sample_aggregator_defines.svh */
// ----------------------------------------------------------------------------
// Ray sample aggregator assertion macros
// Shared property macros for the aggregator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RAY_SAMPLE_AGGREGATOR_DEFINES_SVH
`define RAY_SAMPLE_AGGREGATOR_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define RSA_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ray sample aggregator check failed");

// A consequent that must hold in the same cycle as its antecedent.
`define RSA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ray sample aggregator check failed");

`endif

/* hw/rtl/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// Ray sample aggregator package
// Widths, register codes, fixed-point constants and small helper functions.
// ----------------------------------------------------------------------------
package rsa_pkg;

	// Field and port widths.
	localparam int MAX_RAY_LENGTH_DEF = 256;
	localparam int VOXEL_W    = 16;
	localparam int RAY_W      = 14;
	localparam int MODE_W     = 2;
	localparam int SPACING_W  = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int MUL_W      = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 1'b1;

	// Aggregation modes.
	localparam logic [MODE_W-1:0] MODE_MEAN     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MAX      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOGSUM   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TRANSMIT = 2'd3;

	localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd4096;

	// Sample clamping limits.
	localparam logic signed [12:0] V_MIN      = -13'sd1024;
	localparam logic signed [12:0] V_MAX      = 13'sd4095;
	localparam logic signed [12:0] ABS_CLAMP  = 13'sd3071;
	localparam logic signed [12:0] PEAK_RESET = -13'sd1024;

	// Fixed-point constants.
	localparam logic [31:0] K_EXP      = 32'd20654427;     // log2(e)/300, Q32
	localparam logic [37:0] EXP_OFFSET = 38'd13209605120;  // 8.0 minus 1024*K, Q32
	localparam logic [31:0] LN2_Q32    = 32'd2977044472;
	localparam logic [31:0] LOG2E_FRAC = 32'd1901360723;   // log2(e) - 1, Q32
	localparam logic [31:0] LN2X300    = 32'd3488723990;   // 300*ln2, Q24
	localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
	localparam logic [20:0] A_LIMIT    = 21'd1310720;      // 20.0, Q16.16
	localparam logic [31:0] TR_SCALE   = 32'd4095;
	localparam logic [11:0] ABS_DIV    = 12'd3071;
	localparam logic [3:0]  TERM_FIRST = 4'd2;
	localparam logic [3:0]  TERM_LAST  = 4'd13;

	// Output saturation limits.
	localparam logic signed [16:0] RAY_HI = 17'sd8191;
	localparam logic signed [16:0] RAY_LO = -17'sd8192;

	// floor(2^32 / d) for the divisors used by the series and the absorption term.
	function automatic logic [31:0] recip(input logic [11:0] d);
		logic [31:0] r;
		unique case (d)
			12'd2:   r = 32'd2147483648;
			12'd3:   r = 32'd1431655765;
			12'd4:   r = 32'd1073741824;
			12'd5:   r = 32'd858993459;
			12'd6:   r = 32'd715827882;
			12'd7:   r = 32'd613566756;
			12'd8:   r = 32'd536870912;
			12'd9:   r = 32'd477218588;
			12'd10:  r = 32'd429496729;
			12'd11:  r = 32'd390451572;
			12'd12:  r = 32'd357913941;
			12'd13:  r = 32'd330382099;
			default: r = 32'd1398556;
		endcase
		return r;
	endfunction

	// Saturate a result to the signed output range.
	function automatic logic signed [RAY_W-1:0] sat_ray(input logic signed [16:0] x);
		logic signed [RAY_W-1:0] r;
		if (x > RAY_HI) begin
			r = RAY_HI[RAY_W-1:0];
		end else if (x < RAY_LO) begin
			r = RAY_LO[RAY_W-1:0];
		end else begin
			r = x[RAY_W-1:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/rsa_sample_if.sv */
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one ray sample per transaction.
// ----------------------------------------------------------------------------
interface rsa_sample_if import rsa_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VOXEL_W-1:0] voxel_value;
	logic                      in_volume;
	logic                      last_sample;

	modport source(output valid, voxel_value, in_volume, last_sample, input ready);
	modport sink(input valid, voxel_value, in_volume, last_sample, output ready);
endinterface

/* hw/rtl/rsa_result_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one aggregated ray value per transaction.
// ----------------------------------------------------------------------------
interface rsa_result_if import rsa_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [RAY_W-1:0] ray_value;
	logic                    empty_ray;

	modport source(output valid, ray_value, empty_ray, input ready);
	modport sink(input valid, ray_value, empty_ray, output ready);
endinterface

/* hw/rtl/rsa_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module rsa_mul import rsa_pkg::*; (
	input  logic                 clk,
	input  logic [MUL_W-1:0]     a,
	input  logic [MUL_W-1:0]     b,
	output logic [2*MUL_W-1:0]   p
);

	// Product register; the sequencer reads it in the cycle after it issues the operands.
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

/* hw/rtl/ray_sample_aggregator.sv */
// ----------------------------------------------------------------------------
// Ray sample aggregator
// Accumulates the samples of one ray and emits a mean, max, log-sum-exp or
// transmittance value at the end of the ray.
// ----------------------------------------------------------------------------
// All arithmetic runs through one registered 32 x 32 multiplier under a small
// sequencer, so the block takes one sample at a time. A sample outside the
// volume, or beyond the ray length limit, does not use the multiplier. A
// sample inside the volume runs the exp(v/300) Taylor series, with three
// multiplies for each of its twelve division terms, and the absorption term one
// more constant division. At the end of a ray the result takes further steps:
// no arithmetic for max or an empty ray, a restoring divider for the mean (one
// bit a cycle), the series again for transmittance with a nonzero fraction and,
// for log-sum-exp, normalize one bit a cycle, then 24 squarings. The result sits
// in an output register, and the next sample is accepted while it waits.
`include "ray_sample_aggregator_defines.svh"

module ray_sample_aggregator import rsa_pkg::*; #(
	parameter int MAX_RAY_LENGTH = MAX_RAY_LENGTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	rsa_sample_if.sink            sample,
	rsa_result_if.source          result
);

	localparam int CNT_W = $clog2(MAX_RAY_LENGTH + 1);
	localparam int SUM_W = $clog2(MAX_RAY_LENGTH) + 14;
	localparam int IT_W  = ($clog2(SUM_W) > 5) ? $clog2(SUM_W) : 5;
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RAY_LENGTH);
	localparam logic [IT_W-1:0]  DIV_LAST = IT_W'(SUM_W - 1);
	localparam logic [IT_W-1:0]  SQ_LAST  = IT_W'(23);

	typedef enum logic [4:0] {
		S_IDLE, S_EXP_T, S_EXP_LN, S_SER_INIT, S_SER_REC, S_DIV_QMUL, S_DIV_FIX,
		S_EXP_ACC, S_ABS_REC, S_END, S_MEAN, S_MEAN_RES, S_LOG_NORM, S_LOG_SQ,
		S_LOG_UPD, S_LOG_C, S_LOG_RES, S_TR_M, S_TR_T, S_TR_OUT, S_TR_RES, S_RESULT
	} state_t;

	typedef enum logic [1:0] {CTX_SAMPLE, CTX_TRANS, CTX_ABS} ctx_t;

	state_t state_q;
	ctx_t   ctx_q;

	// Configuration and accumulators.
	logic [MODE_W-1:0]       mode_q;
	logic [SPACING_W-1:0]    spacing_q;
	logic signed [SUM_W-1:0] value_sum_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [12:0]      peak_q;
	logic [47:0]             exp_sum_q;
	logic [31:0]             absorb_q;

	// Working registers of the sequencer.
	logic                    last_q;
	logic [12:0]             vb_q;
	logic [11:0]             c_q;
	logic [4:0]              n_q;
	logic [31:0]             z_q;
	logic [31:0]             x_q;
	logic [31:0]             q_q;
	logic [11:0]             d_q;
	logic [3:0]              k_q;
	logic [33:0]             sum_q;
	logic [32:0]             t_q;
	logic [20:0]             a_q;
	logic [47:0]             s_q;
	logic [5:0]              e_q;
	logic [23:0]             frac_q;
	logic [IT_W-1:0]         it_q;
	logic                    neg_q;
	logic [SUM_W-1:0]        quo_q;
	logic [CNT_W-1:0]        rem_q;
	logic signed [RAY_W-1:0] res_q;
	logic                    empty_q;

	// Output register.
	logic                    out_valid_q;
	logic signed [RAY_W-1:0] out_value_q;
	logic                    out_empty_q;

	// Multiplier operands and product.
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [2*MUL_W-1:0] mul_p;

	// Combinational helpers.
	logic                    accept;
	logic                    take;
	logic                    out_load;
	logic signed [12:0]      vc;
	logic [11:0]             cc;
	logic [31:0]             rem_fix;
	logic [31:0]             q_fix;
	logic [37:0]             t_full;
	logic [36:0]             exp_term;
	logic [48:0]             exp_acc;
	logic [32:0]             absorb_acc;
	logic [53:0]             tr_m;
	logic [20:0]             a_lim;
	logic signed [6:0]       e_m16;
	logic signed [30:0]      l_val;
	logic [30:0]             l_mag;
	logic [31:0]             sq_y;
	logic [CNT_W:0]          r_try;
	logic                    r_ge;
	logic signed [16:0]      log_r;

	rsa_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign accept = sample.valid & sample.ready;
	assign take   = sample.in_volume & (count_q < CNT_MAX);
	assign sample.ready = (state_q == S_IDLE);

	// A finished ray moves into the output register once it is free or draining.
	assign out_load = (state_q == S_RESULT) && (!out_valid_q || result.ready);

	assign result.valid     = out_valid_q;
	assign result.ray_value = out_value_q;
	assign result.empty_ray = out_empty_q;

	// Sample clamping and datapath helpers.
	always_comb begin
		if (sample.voxel_value < 16'(V_MIN)) begin
			vc = V_MIN;
		end else if (sample.voxel_value > 16'(V_MAX)) begin
			vc = V_MAX;
		end else begin
			vc = sample.voxel_value[12:0];
		end
		if (vc < 13'sd0) begin
			cc = '0;
		end else if (vc > ABS_CLAMP) begin
			cc = ABS_CLAMP[11:0];
		end else begin
			cc = vc[11:0];
		end

		// Constant division correction: the estimate is at most one short.
		rem_fix = x_q - mul_p[31:0];
		q_fix   = (rem_fix >= {20'b0, d_q}) ? q_q + 32'd1 : q_q;

		t_full = mul_p[37:0] + EXP_OFFSET;

		if (n_q >= 5'd24) begin
			exp_term = {3'b0, sum_q} << (n_q - 5'd24);
		end else begin
			exp_term = {3'b0, sum_q} >> (5'd24 - n_q);
		end
		exp_acc    = {1'b0, exp_sum_q} + {12'b0, exp_term};
		absorb_acc = {1'b0, absorb_q} + {1'b0, q_fix};

		tr_m  = mul_p[53:0] + {1'b0, a_q, 32'b0};
		a_lim = ({1'b0, absorb_q[31:1]} > {11'b0, A_LIMIT}) ? A_LIMIT : absorb_q[21:1];

		e_m16 = $signed({1'b0, e_q}) - 7'sd16;
		l_val = {e_m16, frac_q};
		l_mag = l_val[30] ? 31'(-l_val) : l_val;
		sq_y  = mul_p[61:30];

		r_try = {rem_q, quo_q[SUM_W-1]};
		r_ge  = (r_try >= {1'b0, count_q});

		log_r = neg_q ? -$signed({1'b0, mul_p[63:48]}) : $signed({1'b0, mul_p[63:48]});
	end

	// Multiplier operand selection per sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_EXP_T: begin
				mul_a = {19'b0, vb_q};
				mul_b = K_EXP;
			end
			S_EXP_LN: begin
				mul_a = t_full[31:0];
				mul_b = LN2_Q32;
			end
			S_SER_INIT: begin
				mul_a = mul_p[63:32];
				mul_b = mul_p[63:32];
			end
			S_SER_REC: begin
				mul_a = mul_p[63:32];
				mul_b = recip({8'b0, k_q});
			end
			S_DIV_QMUL: begin
				mul_a = mul_p[63:32];
				mul_b = {20'b0, d_q};
			end
			S_DIV_FIX: begin
				mul_a = q_fix;
				mul_b = z_q;
			end
			S_EXP_ACC: begin
				mul_a = {20'b0, c_q};
				mul_b = {16'b0, spacing_q};
			end
			S_ABS_REC: begin
				mul_a = {mul_p[27:0], 4'b0};
				mul_b = recip(ABS_DIV);
			end
			S_END: begin
				mul_a = {11'b0, a_lim};
				mul_b = LOG2E_FRAC;
			end
			S_TR_M: begin
				mul_a = 32'(ONE_Q32 - {1'b0, tr_m[47:16]});
				mul_b = LN2_Q32;
			end
			S_LOG_SQ: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			S_LOG_C: begin
				mul_a = {1'b0, l_mag};
				mul_b = LN2X300;
			end
			S_TR_OUT: begin
				mul_a = 32'(ONE_Q32 - t_q);
				mul_b = TR_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Sequencer, accumulators, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ctx_q       <= CTX_SAMPLE;
			mode_q      <= MODE_MEAN;
			spacing_q   <= SPACING_RESET;
			value_sum_q <= '0;
			count_q     <= '0;
			peak_q      <= PEAK_RESET;
			exp_sum_q   <= '0;
			absorb_q    <= '0;
			last_q      <= 1'b0;
			vb_q        <= '0;
			c_q         <= '0;
			n_q         <= '0;
			z_q         <= '0;
			x_q         <= '0;
			q_q         <= '0;
			d_q         <= '0;
			k_q         <= '0;
			sum_q       <= '0;
			t_q         <= '0;
			a_q         <= '0;
			s_q         <= '0;
			e_q         <= '0;
			frac_q      <= '0;
			it_q        <= '0;
			neg_q       <= 1'b0;
			quo_q       <= '0;
			rem_q       <= '0;
			res_q       <= '0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_empty_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE:    mode_q    <= cfg_wdata[MODE_W-1:0];
					CFG_SPACING: spacing_q <= cfg_wdata[SPACING_W-1:0];
				endcase
			end

			// A finished ray fills the output register; the downstream side drains it.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= sample.last_sample;
						ctx_q  <= CTX_SAMPLE;
						vb_q   <= 13'(vc + 13'sd1024);
						c_q    <= cc;
						if (take) begin
							value_sum_q <= value_sum_q + SUM_W'(vc);
							count_q     <= count_q + CNT_W'(1);
							if (vc > peak_q) begin
								peak_q <= vc;
							end
							state_q <= S_EXP_T;
						end else if (sample.last_sample) begin
							state_q <= S_END;
						end
					end
				end
				S_EXP_T: begin
					state_q <= S_EXP_LN;
				end
				S_EXP_LN: begin
					n_q     <= t_full[36:32];
					state_q <= S_SER_INIT;
				end
				// First series term equals z, so the sum starts at 1 + z.
				S_SER_INIT: begin
					z_q     <= mul_p[63:32];
					sum_q   <= {1'b0, ONE_Q32} + {2'b0, mul_p[63:32]};
					k_q     <= TERM_FIRST;
					state_q <= S_SER_REC;
				end
				S_SER_REC: begin
					x_q     <= mul_p[63:32];
					d_q     <= {8'b0, k_q};
					state_q <= S_DIV_QMUL;
				end
				S_DIV_QMUL: begin
					q_q     <= mul_p[63:32];
					state_q <= S_DIV_FIX;
				end
				S_DIV_FIX: begin
					if (ctx_q == CTX_ABS) begin
						absorb_q <= absorb_acc[32] ? '1 : absorb_acc[31:0];
						state_q  <= last_q ? S_END : S_IDLE;
					end else begin
						sum_q <= sum_q + {2'b0, q_fix};
						if (k_q == TERM_LAST) begin
							state_q <= (ctx_q == CTX_SAMPLE) ? S_EXP_ACC : S_TR_T;
						end else begin
							k_q     <= k_q + 4'd1;
							state_q <= S_SER_REC;
						end
					end
				end
				S_EXP_ACC: begin
					exp_sum_q <= exp_acc[48] ? '1 : exp_acc[47:0];
					state_q   <= S_ABS_REC;
				end
				S_ABS_REC: begin
					x_q     <= {mul_p[27:0], 4'b0};
					d_q     <= ABS_DIV;
					ctx_q   <= CTX_ABS;
					state_q <= S_DIV_QMUL;
				end
				// End of ray: pick the aggregation.
				S_END: begin
					empty_q <= (count_q == '0);
					a_q     <= a_lim;
					if (count_q == '0) begin
						res_q   <= '0;
						state_q <= S_RESULT;
					end else begin
						unique case (mode_q)
							MODE_MEAN: begin
								neg_q   <= value_sum_q[SUM_W-1];
								quo_q   <= value_sum_q[SUM_W-1] ?
									SUM_W'(-value_sum_q) : SUM_W'(value_sum_q);
								rem_q   <= '0;
								it_q    <= '0;
								state_q <= S_MEAN;
							end
							MODE_MAX: begin
								res_q   <= {peak_q[12], peak_q};
								state_q <= S_RESULT;
							end
							MODE_LOGSUM: begin
								s_q     <= exp_sum_q;
								e_q     <= 6'd47;
								state_q <= S_LOG_NORM;
							end
							MODE_TRANSMIT: begin
								state_q <= S_TR_M;
							end
						endcase
					end
				end
				// Restoring division of the sum magnitude by the count.
				S_MEAN: begin
					rem_q <= r_ge ? CNT_W'(r_try - {1'b0, count_q}) : r_try[CNT_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], r_ge};
					it_q  <= it_q + IT_W'(1);
					if (it_q == DIV_LAST) begin
						state_q <= S_MEAN_RES;
					end
				end
				S_MEAN_RES: begin
					res_q   <= neg_q ? -$signed(quo_q[RAY_W-1:0]) : $signed(quo_q[RAY_W-1:0]);
					state_q <= S_RESULT;
				end
				// Normalize the exp sum until its top bit is set or the exponent reaches zero.
				S_LOG_NORM: begin
					if (s_q[47] || (e_q == '0)) begin
						x_q     <= {1'b0, s_q[47:17]};
						frac_q  <= '0;
						it_q    <= '0;
						state_q <= S_LOG_SQ;
					end else begin
						s_q <= {s_q[46:0], 1'b0};
						e_q <= e_q - 6'd1;
					end
				end
				S_LOG_SQ: begin
					state_q <= S_LOG_UPD;
				end
				// One fraction bit of log2 per squaring.
				S_LOG_UPD: begin
					if (sq_y[31]) begin
						x_q    <= {1'b0, sq_y[31:1]};
						frac_q <= {frac_q[22:0], 1'b1};
					end else begin
						x_q    <= sq_y;
						frac_q <= {frac_q[22:0], 1'b0};
					end
					it_q <= it_q + IT_W'(1);
					state_q <= (it_q == SQ_LAST) ? S_LOG_C : S_LOG_SQ;
				end
				S_LOG_C: begin
					neg_q   <= l_val[30];
					state_q <= S_LOG_RES;
				end
				S_LOG_RES: begin
					res_q   <= sat_ray(log_r);
					state_q <= S_RESULT;
				end
				// Split the scaled absorption into integer and fraction of log2.
				S_TR_M: begin
					if (tr_m[47:16] == '0) begin
						t_q     <= ONE_Q32 >> tr_m[52:48];
						state_q <= S_TR_OUT;
					end else begin
						n_q     <= tr_m[52:48];
						ctx_q   <= CTX_TRANS;
						state_q <= S_SER_INIT;
					end
				end
				S_TR_T: begin
					t_q     <= 33'(sum_q >> ({1'b0, n_q} + 6'd1));
					state_q <= S_TR_OUT;
				end
				S_TR_OUT: begin
					state_q <= S_TR_RES;
				end
				S_TR_RES: begin
					res_q   <= {2'b0, mul_p[43:32]};
					state_q <= S_RESULT;
				end
				// Hand the result to the output register and start a new ray.
				S_RESULT: begin
					if (out_load) begin
						out_value_q <= res_q;
						out_empty_q <= empty_q;
						value_sum_q <= '0;
						count_q     <= '0;
						peak_q      <= PEAK_RESET;
						exp_sum_q   <= '0;
						absorb_q    <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencer and the accumulators.
	`RSA_ASSERT_ALWAYS(a_count_limit, count_q <= CNT_MAX)
	`RSA_ASSERT_IMP(a_empty_zero, result.valid && result.empty_ray, result.ray_value == '0)
	`RSA_ASSERT_IMP(a_term_range, state_q == S_DIV_FIX && ctx_q != CTX_ABS, k_q >= TERM_FIRST && k_q <= TERM_LAST)

endmodule
